// ----- sv/cfw_pkg.sv -----
// Package for the circular FIFO with dump: request, status and cell codes,
// the cell control bundle and shared widths. No dependencies.
package cfw_pkg;

    localparam int DataW        = 32;
    localparam int ReqW         = 2;
    localparam int StatW        = 2;
    localparam int DefaultDepth = 8;

    typedef enum logic [ReqW-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_DUMP   = 2'd2
    } req_type_t;

    typedef enum logic [StatW-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_SHIFT,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_DUMP
    } fsm_state_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DataW-1:0]  push_value;
    } cell_ctrl_t;

endpackage

// ----- sv/circular_fifo_with_dump.sv -----
// Circular FIFO of signed words with insert, delete and dump requests.
// Top level: controller, output register and the chain of cfw_cell.
// Depends on cfw_pkg and cfw_cell.
//
// Usage:
//   Slave side takes one request per beat: tuser holds req_type, tdata the
//   value to insert. Master side returns results: tuser holds status, tdata
//   the word read, tlast marks the final result of a request.
//   With the receiver ready, a new insert or delete request is taken every
//   cycle, and its result is shown in the next cycle.
//   A dump of N stored words gives the request beat, then one result beat
//   per word while the chain rotates once around its occupied cells, which
//   leaves the order unchanged. No request is taken meanwhile.
//   A dump of an empty queue gives one empty result. Request code 3 is
//   taken and dropped.
//   Reset empties the queue and the output register.
//   A stalled receiver holds the output register; new requests wait until
//   it is taken, so nothing is lost or repeated.
module circular_fifo_with_dump
#(
    parameter int DEPTH = cfw_pkg::DefaultDepth
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] push_value
    input  logic signed [cfw_pkg::DataW-1:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [cfw_pkg::ReqW-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] read_value
    output logic signed [cfw_pkg::DataW-1:0] m_axis_tdata,
    // [1:0] status
    output logic [cfw_pkg::StatW-1:0]        m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int CntW = $clog2(DEPTH + 1);

    cfw_pkg::fsm_state_t              state_reg;
    cfw_pkg::fsm_state_t              state_next;
    logic [CntW-1:0]                  occ_reg;
    logic [CntW-1:0]                  occ_next;
    logic [CntW-1:0]                  remain_reg;
    logic [CntW-1:0]                  remain_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    cfw_pkg::status_t                 out_status_reg;
    cfw_pkg::status_t                 out_status_next;
    logic signed [cfw_pkg::DataW-1:0] out_data_reg;
    logic signed [cfw_pkg::DataW-1:0] out_data_next;
    logic                             out_last_reg;
    logic                             out_last_next;

    cfw_pkg::cell_ctrl_t              cell_ctrl;
    logic signed [cfw_pkg::DataW-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]                 cell_valid;
    logic signed [cfw_pkg::DataW-1:0] head_data;
    logic                             out_free;
    logic                             accept;
    logic                             full;
    logic                             empty;
    cfw_pkg::req_type_t               req;

    assign head_data     = cell_data[0];
    assign full          = cell_valid[DEPTH-1];
    assign empty         = !cell_valid[0];
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == cfw_pkg::FSM_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req           = cfw_pkg::req_type_t'(s_axis_tuser);

    always_comb
    begin
        state_next           = state_reg;
        occ_next             = occ_reg;
        remain_next          = remain_reg;
        out_valid_next       = out_valid_reg && !m_axis_tready;
        out_status_next      = out_status_reg;
        out_data_next        = out_data_reg;
        out_last_next        = out_last_reg;
        cell_ctrl.op         = cfw_pkg::OP_HOLD;
        cell_ctrl.push_value = s_axis_tdata;
        case (state_reg)
            cfw_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    case (req)
                        cfw_pkg::REQ_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_last_next  = 1'b1;
                            if (full)
                            begin
                                out_status_next = cfw_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                out_status_next = cfw_pkg::ST_OK;
                                cell_ctrl.op    = cfw_pkg::OP_PUSH;
                                occ_next        = occ_reg + CntW'(1);
                            end
                        end
                        cfw_pkg::REQ_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (empty)
                            begin
                                out_status_next = cfw_pkg::ST_EMPTY;
                                out_data_next   = '0;
                            end
                            else
                            begin
                                out_status_next = cfw_pkg::ST_OK;
                                out_data_next   = head_data;
                                cell_ctrl.op    = cfw_pkg::OP_SHIFT;
                                occ_next        = occ_reg - CntW'(1);
                            end
                        end
                        cfw_pkg::REQ_DUMP:
                        begin
                            if (empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = cfw_pkg::ST_EMPTY;
                                out_data_next   = '0;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                state_next  = cfw_pkg::FSM_DUMP;
                                remain_next = occ_reg;
                            end
                        end
                        default:
                        begin
                            state_next = cfw_pkg::FSM_IDLE;
                        end
                    endcase
                end
            end
            cfw_pkg::FSM_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = cfw_pkg::ST_OK;
                    out_data_next   = head_data;
                    out_last_next   = (remain_reg == CntW'(1));
                    cell_ctrl.op    = cfw_pkg::OP_ROTATE;
                    remain_next     = remain_reg - CntW'(1);
                    if (remain_reg == CntW'(1))
                    begin
                        state_next = cfw_pkg::FSM_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = cfw_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfw_pkg::FSM_IDLE;
            occ_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [cfw_pkg::DataW-1:0] nb_data;
            logic                             nb_valid;
            logic                             pv_valid;

            if (gi < DEPTH - 1)
            begin : g_mid
                assign nb_data  = cell_data[gi+1];
                assign nb_valid = cell_valid[gi+1];
            end
            else
            begin : g_end
                assign nb_data  = '0;
                assign nb_valid = 1'b0;
            end

            if (gi > 0)
            begin : g_prev
                assign pv_valid = cell_valid[gi-1];
            end
            else
            begin : g_first
                assign pv_valid = 1'b1;
            end

            cfw_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .head_data  (head_data),
                .next_data  (nb_data),
                .next_valid (nb_valid),
                .prev_valid (pv_valid),
                .data       (cell_data[gi]),
                .valid      (cell_valid[gi])
            );
        end
    endgenerate

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_valid ^ (cell_valid >> 1)))
        else $error("occupied cells not contiguous from the head");

    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_reg == '0) == empty) && ((occ_reg == CntW'(DEPTH)) == full))
        else $error("occupancy count disagrees with cell chain");

    a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfw_pkg::FSM_DUMP) |-> (remain_reg != '0) && (remain_reg <= occ_reg))
        else $error("dump counter out of range");
`endif

endmodule

// ----- sv/cfw_cell.sv -----
// One storage cell of the FIFO chain: a word and its occupied flag.
// Depends on cfw_pkg.
module cfw_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfw_pkg::cell_ctrl_t             ctrl,
    input  logic signed [cfw_pkg::DataW-1:0] head_data,
    input  logic signed [cfw_pkg::DataW-1:0] next_data,
    input  logic                            next_valid,
    input  logic                            prev_valid,
    output logic signed [cfw_pkg::DataW-1:0] data,
    output logic                            valid
);

    logic signed [cfw_pkg::DataW-1:0] data_reg;
    logic signed [cfw_pkg::DataW-1:0] data_next;
    logic                             valid_reg;
    logic                             valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            cfw_pkg::OP_PUSH:
            begin
                if (!valid_reg && prev_valid)
                begin
                    data_next  = ctrl.push_value;
                    valid_next = 1'b1;
                end
            end
            cfw_pkg::OP_SHIFT:
            begin
                data_next  = next_data;
                valid_next = next_valid;
            end
            cfw_pkg::OP_ROTATE:
            begin
                if (valid_reg)
                begin
                    data_next = next_valid ? next_data : head_data;
                end
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ----- test/circular_fifo_with_dump_test.sv -----
// Testbench for circular_fifo_with_dump: directed and random request streams,
// each result beat checked against a queue model kept in this file.
// Depends on cfw_pkg and the circular_fifo_with_dump RTL.
module circular_fifo_with_dump_test;

    localparam int                         DEPTH       = 8;
    localparam int                         CYCLE_LIMIT = 200000;
    localparam int                         MAX_REPORTS = 10;
    localparam logic [cfw_pkg::ReqW-1:0]   REQ_UNUSED  = 2'd3;
    localparam logic signed [31:0]         WORD_MIN    = 32'sh8000_0000;
    localparam logic signed [31:0]         WORD_MAX    = 32'sh7FFF_FFFF;

    typedef struct {
        cfw_pkg::status_t                 status;
        logic signed [cfw_pkg::DataW-1:0] word;
        logic                             last;
    } fifo_response_t;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic signed [cfw_pkg::DataW-1:0] s_axis_tdata  = '0;
    logic [cfw_pkg::ReqW-1:0]         s_axis_tuser  = cfw_pkg::REQ_INSERT;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic signed [cfw_pkg::DataW-1:0] m_axis_tdata;
    logic [cfw_pkg::StatW-1:0]        m_axis_tuser;
    logic                             m_axis_tlast;

    fifo_response_t                   awaited_responses[$];
    logic signed [cfw_pkg::DataW-1:0] model_words[DEPTH];
    int                               model_head     = 0;
    int                               model_tail     = 0;
    int                               model_fill     = 0;
    int                               send_idle_pct  = 0;
    int                               recv_idle_pct  = 0;
    int                               mismatch_count = 0;
    int                               cycle_count    = 0;

    circular_fifo_with_dump #(
        .DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void push_response(cfw_pkg::status_t status,
                                          logic signed [cfw_pkg::DataW-1:0] word,
                                          logic last);
        fifo_response_t resp;
        resp.status = status;
        resp.word   = word;
        resp.last   = last;
        awaited_responses.push_back(resp);
    endfunction

    function automatic void predict_fifo_response(logic [cfw_pkg::ReqW-1:0] req,
                                                  logic signed [cfw_pkg::DataW-1:0] value);
        int pos;
        if (req == cfw_pkg::REQ_INSERT)
        begin
            if (model_fill == DEPTH)
                push_response(cfw_pkg::ST_OVERFLOW, '0, 1'b1);
            else
            begin
                model_words[model_tail] = value;
                model_tail = (model_tail + 1) % DEPTH;
                model_fill++;
                push_response(cfw_pkg::ST_OK, '0, 1'b1);
            end
        end
        else if (req == cfw_pkg::REQ_DELETE)
        begin
            if (model_fill == 0)
                push_response(cfw_pkg::ST_EMPTY, '0, 1'b1);
            else
            begin
                push_response(cfw_pkg::ST_OK, model_words[model_head], 1'b1);
                model_head = (model_head + 1) % DEPTH;
                model_fill--;
            end
        end
        else if (req == cfw_pkg::REQ_DUMP)
        begin
            if (model_fill == 0)
                push_response(cfw_pkg::ST_EMPTY, '0, 1'b1);
            else
            begin
                pos = model_head;
                for (int k = 0; k < model_fill; k++)
                begin
                    push_response(cfw_pkg::ST_OK, model_words[pos], k == model_fill - 1);
                    pos = (pos + 1) % DEPTH;
                end
            end
        end
    endfunction

    always @(negedge clk)
    begin : check_beat
        fifo_response_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_responses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected beat: status %0d word %h last %b",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (m_axis_tuser !== want.status || m_axis_tdata !== want.word
                    || m_axis_tlast !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: status %0d/%0d word %h/%h last %b/%b",
                                 want.status, m_axis_tuser, want.word, m_axis_tdata,
                                 want.last, m_axis_tlast);
                end
            end
        end
    end

    // Call at a rising edge; returns at the rising edge that takes the beat.
    task automatic send_request(input logic [cfw_pkg::ReqW-1:0] req,
                                input logic signed [cfw_pkg::DataW-1:0] value);
        logic taken;
        taken = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= req;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_axis_tready;
            if (taken)
                predict_fifo_response(req, value);
            @(posedge clk);
        end
    endtask

    function automatic logic signed [cfw_pkg::DataW-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_queue();
        send_request(cfw_pkg::REQ_DELETE, pick_word());
        send_request(cfw_pkg::REQ_DUMP, pick_word());
    endtask

    task automatic test_fill_and_overflow();
        send_request(cfw_pkg::REQ_INSERT, WORD_MIN);
        send_request(cfw_pkg::REQ_INSERT, WORD_MAX);
        send_request(cfw_pkg::REQ_INSERT, 32'sh0000_0000);
        send_request(cfw_pkg::REQ_INSERT, -32'sd1);
        send_request(cfw_pkg::REQ_INSERT, 32'sh5555_5555);
        send_request(cfw_pkg::REQ_INSERT, 32'shAAAA_AAAA);
        send_request(cfw_pkg::REQ_INSERT, 32'sd1);
        send_request(cfw_pkg::REQ_INSERT, 32'sd2);
        send_request(cfw_pkg::REQ_INSERT, 32'sh1234_5678);
        send_request(cfw_pkg::REQ_DUMP, '0);
    endtask

    task automatic test_wrap_around();
        repeat (3)
            send_request(cfw_pkg::REQ_DELETE, '0);
        send_request(cfw_pkg::REQ_INSERT, 32'sh0BAD_F00D);
        send_request(cfw_pkg::REQ_INSERT, 32'sh7654_3210);
        send_request(cfw_pkg::REQ_DUMP, '0);
    endtask

    task automatic test_unused_code();
        send_request(REQ_UNUSED, 32'shFFFF_FFFF);
    endtask

    task automatic test_drain_to_empty();
        while (model_fill > 0)
            send_request(cfw_pkg::REQ_DELETE, '0);
    endtask

    task automatic test_random_traffic(input int item_count);
        int  sent;
        int  roll;
        bit  filling;
        sent    = 0;
        filling = 1'b1;
        while (sent < item_count)
        begin
            if (model_fill == DEPTH || $urandom_range(0, 19) == 0)
                filling = 1'b0;
            if (model_fill == 0 || $urandom_range(0, 19) == 0)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                send_request(REQ_UNUSED, pick_word());
            else
            begin
                if (roll < 18)
                    send_request(cfw_pkg::REQ_DUMP, pick_word());
                else if (roll < (filling ? 78 : 40))
                    send_request(cfw_pkg::REQ_INSERT, pick_word());
                else
                    send_request(cfw_pkg::REQ_DELETE, pick_word());
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 56;
        test_empty_queue();
        test_fill_and_overflow();
        test_wrap_around();
        test_unused_code();
        test_drain_to_empty();
        test_random_traffic(70);

        send_idle_pct = 56;
        recv_idle_pct = 7;
        test_random_traffic(70);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(65);

        s_axis_tvalid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
